/* hdl/ops_pkg.sv */
// Shared types and constants of the oil paint filter.
// Used by every module of the block but the command queue; depends on nothing.
package ops_pkg;

	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int ROW_W     = 12;
	localparam int OUT_X_W   = 11;
	localparam int CFG_W     = 12;
	localparam int LVL_W     = 6;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 2'd2;

	// Reset values of the registers.
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [LVL_W-1:0] LEVEL_RESET  = 6'd20;

	// Division by three as a multiply by a reciprocal: (s * 683) >> 11 is exact for s <= 765.
	localparam int SUM3_W = CH_W + 2;
	localparam logic [SUM3_W-1:0] RECIP3 = 10'd683;
	localparam int RECIP3_SHIFT = 11;

	typedef logic [PIX_W-1:0] pixel_t;

	// What a command asks of the back end.
	typedef struct packed {
		logic interior;
		logic pass;
	} ops_kind_t;

endpackage

/* hdl/ops_front.sv */
// Front end: pixel intake, raster position, line store and command building.
// Depends on ops_pkg.
module ops_front #(
	parameter int RADIUS    = 3,
	parameter int MAX_WIDTH = 2048,
	parameter int CW        = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic                              frame_start,
	input  ops_pkg::pixel_t                   pix,
	input  logic [ops_pkg::CFG_W-1:0]         cfg_width,
	input  logic [ops_pkg::CFG_W-1:0]         cfg_height,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output logic [(2*RADIUS+1)*ops_pkg::PIX_W-1:0] cmd_col,
	output ops_pkg::ops_kind_t                cmd_kind,
	output logic [CW-1:0]                     cmd_x,
	output logic [ops_pkg::ROW_W-1:0]         cmd_y
);
	import ops_pkg::*;

	localparam int LS = 2 * RADIUS;
	localparam int AW = $clog2(MAX_WIDTH);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_PUSH = 2'b10
	} fstate_t;

	fstate_t                state_q;
	logic [LS*PIX_W-1:0]    line_mem [MAX_WIDTH];
	logic [LS*PIX_W-1:0]    rd_q;
	logic [CW-1:0]          col_q;
	logic [ROW_W-1:0]       row_q;
	logic [CW-1:0]          x_q;
	logic [ROW_W-1:0]       y_q;
	pixel_t                 pix_q;
	logic [CFG_W+CW-1:0]    w_wide;
	logic [CW-1:0]          w_eff;
	logic [ROW_W-1:0]       h_eff;
	logic [CW:0]            cc;
	logic [ROW_W:0]         rr;
	logic [CW-1:0]          x_c;
	logic [ROW_W-1:0]       y_c;
	logic [CW:0]            x_inc;
	logic [ROW_W:0]         y_inc;
	logic [CW-1:0]          col_n;
	logic [ROW_W-1:0]       row_n;
	logic                   accept;
	logic                   push;

	// Effective frame size.
	assign w_wide = {{CW{1'b0}}, cfg_width};
	assign w_eff  = (w_wide == '0) ? CW'(1) :
		(w_wide > (CFG_W+CW)'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_wide[CW-1:0];
	assign h_eff  = (cfg_height == '0) ? ROW_W'(1) : cfg_height;

	assign accept    = pix_valid && !pix_stall;
	assign pix_stall = (state_q != F_IDLE);
	assign cmd_valid = (state_q == F_PUSH);
	assign push      = cmd_valid && cmd_ready;

	// Position of the arriving pixel, including wrap after a shrunk frame size.
	always_comb begin
		cc = frame_start ? '0 : {1'b0, col_q};
		rr = frame_start ? '0 : {1'b0, row_q};
		if (cc >= {1'b0, w_eff}) begin
			cc = '0;
			rr = rr + 1'b1;
		end
		if (rr >= {1'b0, h_eff}) begin
			rr = '0;
		end
		x_c   = cc[CW-1:0];
		y_c   = rr[ROW_W-1:0];
		x_inc = {1'b0, x_c} + 1'b1;
		y_inc = {1'b0, y_c} + 1'b1;
		if (x_inc >= {1'b0, w_eff}) begin
			col_n = '0;
			row_n = (y_inc >= {1'b0, h_eff}) ? '0 : y_inc[ROW_W-1:0];
		end else begin
			col_n = x_inc[CW-1:0];
			row_n = y_c;
		end
	end

	// Control state and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						col_q   <= col_n;
						row_q   <= row_n;
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Pixel and position of the transaction in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= x_c;
			y_q   <= y_c;
			pix_q <= pix;
		end
	end

	// Line store: one row per column, oldest line in the low entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[x_c[AW-1:0]];
		end
		if (push) begin
			line_mem[x_q[AW-1:0]] <= cmd_col[(LS+1)*PIX_W-1:PIX_W];
		end
	end

	// Window column through this pixel and its classification.
	assign cmd_col = {pix_q, rd_q};
	assign cmd_x   = x_q;
	assign cmd_y   = y_q;
	assign cmd_kind.interior = (x_q >= CW'(LS)) && (y_q >= ROW_W'(LS));
	assign cmd_kind.pass = (x_q < CW'(RADIUS)) || (y_q < ROW_W'(RADIUS)) ||
		(({1'b0, x_q} + (CW+1)'(RADIUS)) >= {1'b0, w_eff}) ||
		(({1'b0, y_q} + (ROW_W+1)'(RADIUS)) >= {1'b0, h_eff});

	a_accept_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == F_PUSH) else $error("front did not move to push");
	a_push_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> state_q == F_IDLE) else $error("front did not return to idle");
	a_col_advance: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (col_q == '0) || ({1'b0, col_q} == ({1'b0, x_q} + 1'b1)))
		else $error("column counter did not advance");

endmodule

/* hdl/ops_cmd_fifo.sv */
// Two-entry command queue between the front and back ends.
// Depends on nothing.
module ops_cmd_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/ops_back.sv */
// Back end: window, histogram over the window, fullest-bin search, mean division, results.
// Depends on ops_pkg.
module ops_back #(
	parameter int RADIUS     = 3,
	parameter int MAX_LEVELS = 32,
	parameter int CW         = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cmd_valid,
	output logic                                   cmd_ready,
	input  logic [(2*RADIUS+1)*ops_pkg::PIX_W-1:0] cmd_col,
	input  ops_pkg::ops_kind_t                     cmd_kind,
	input  logic [CW-1:0]                          cmd_x,
	input  logic [ops_pkg::ROW_W-1:0]              cmd_y,
	input  logic [ops_pkg::LVL_W-1:0]              cfg_levels,
	output logic                                   res_valid,
	input  logic                                   res_stall,
	output logic [ops_pkg::OUT_X_W-1:0]            out_x,
	output logic [ops_pkg::ROW_W-1:0]              out_y,
	output logic [ops_pkg::CH_W-1:0]               out_red,
	output logic [ops_pkg::CH_W-1:0]               out_green,
	output logic [ops_pkg::CH_W-1:0]               out_blue,
	output logic                                   last_of_run
);
	import ops_pkg::*;

	localparam int D      = 2 * RADIUS + 1;
	localparam int NWIN   = D * D;
	localparam int FW     = $clog2(NWIN + 1);
	localparam int CNT_W  = $clog2(NWIN + 1);
	localparam int SUM_W  = $clog2(NWIN * 255 + 1);
	localparam int LW     = $clog2(MAX_LEVELS + 1);
	localparam int BW     = $clog2(MAX_LEVELS);
	localparam int IW     = $clog2(SUM_W + 1);

	typedef enum logic [5:0] {
		B_IDLE   = 6'b000001,
		B_BIN    = 6'b000010,
		B_SEARCH = 6'b000100,
		B_DIV    = 6'b001000,
		B_EMIT_I = 6'b010000,
		B_EMIT_P = 6'b100000
	} bstate_t;

	// One restoring division step: returns {remainder, shifted numerator with quotient bit}.
	function automatic logic [CNT_W+SUM_W-1:0] div_step(input logic [CNT_W-1:0] rem,
		input logic [SUM_W-1:0] num, input logic [CNT_W-1:0] den);
		logic [CNT_W:0] trial;
		logic [CNT_W:0] diff;
		trial = {rem, num[SUM_W-1]};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			div_step = {diff[CNT_W-1:0], num[SUM_W-2:0], 1'b1};
		end else begin
			div_step = {trial[CNT_W-1:0], num[SUM_W-2:0], 1'b0};
		end
	endfunction

	bstate_t             state_q;
	pixel_t              win_q [NWIN];
	ops_kind_t           kind_q;
	logic [CW-1:0]       x_q;
	logic [ROW_W-1:0]    y_q;
	pixel_t              pix_q;
	logic [FW-1:0]       feed_q;
	logic                v_s1;
	logic                v_s2;
	logic [CH_W-1:0]     q_s1;
	pixel_t              rgb_s1;
	pixel_t              rgb_s2;
	logic [BW-1:0]       bin_s2;
	logic [CNT_W-1:0]    cnt_q [MAX_LEVELS];
	logic [SUM_W-1:0]    sr_q [MAX_LEVELS];
	logic [SUM_W-1:0]    sg_q [MAX_LEVELS];
	logic [SUM_W-1:0]    sb_q [MAX_LEVELS];
	logic [LW-1:0]       srch_q;
	logic [CNT_W-1:0]    best_q;
	logic [SUM_W-1:0]    nr_q;
	logic [SUM_W-1:0]    ng_q;
	logic [SUM_W-1:0]    nb_q;
	logic [CNT_W-1:0]    rr_q;
	logic [CNT_W-1:0]    rg_q;
	logic [CNT_W-1:0]    rb_q;
	logic [IW-1:0]       iter_q;
	logic                res_valid_q;
	logic [OUT_X_W-1:0]  out_x_q;
	logic [ROW_W-1:0]    out_y_q;
	pixel_t              out_pix_q;
	logic                last_q;

	logic [LVL_W+LW-1:0]  lv_wide;
	logic [LW-1:0]        lv_eff;
	logic                 pop;
	logic                 feeding;
	logic                 load_ok;
	logic                 emit;
	logic [SUM3_W-1:0]    sum3;
	logic [2*SUM3_W-1:0]  prod3;
	logic [CH_W+LW-1:0]   prodl;
	logic [LW-1:0]        binw;
	logic [CNT_W+SUM_W-1:0] dr;
	logic [CNT_W+SUM_W-1:0] dg;
	logic [CNT_W+SUM_W-1:0] db;
	logic [CW-1:0]        ix;
	logic [CW+OUT_X_W-1:0] ix_ext;
	logic [CW+OUT_X_W-1:0] px_ext;
	pixel_t               mean;

	// Effective level count.
	assign lv_wide = {{LW{1'b0}}, cfg_levels};
	assign lv_eff  = (lv_wide == '0) ? LW'(1) :
		(lv_wide > (LVL_W+LW)'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : lv_wide[LW-1:0];

	assign cmd_ready = (state_q == B_IDLE);
	assign pop       = cmd_valid && cmd_ready;
	assign feeding   = (state_q == B_BIN) && (feed_q < FW'(NWIN));
	assign load_ok   = !res_valid_q || !res_stall;
	assign emit      = ((state_q == B_EMIT_I) || (state_q == B_EMIT_P)) && load_ok;

	// Window shift register: a new column per transaction, full rotation while binning.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < NWIN - D; i++) begin
				win_q[i] <= win_q[i+D];
			end
			for (int k = 0; k < D; k++) begin
				win_q[NWIN-D+k] <= cmd_col[k*PIX_W +: PIX_W];
			end
		end else if (feeding) begin
			for (int i = 0; i < NWIN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[NWIN-1] <= win_q[0];
		end
	end

	// Bin pipeline, stage 1: intensity as (r+g+b)/3.
	assign sum3  = {2'b00, win_q[0][2*CH_W +: CH_W]} + {2'b00, win_q[0][CH_W +: CH_W]} +
		{2'b00, win_q[0][0 +: CH_W]};
	assign prod3 = sum3 * RECIP3;

	// Stage 2: bin index, clamped to the level count.
	assign prodl = q_s1 * lv_eff;
	always_comb begin
		binw = prodl[CH_W +: LW];
		if (binw >= lv_eff) begin
			binw = lv_eff - LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= feeding;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		q_s1   <= prod3[RECIP3_SHIFT +: CH_W];
		rgb_s1 <= win_q[0];
		bin_s2 <= binw[BW-1:0];
		rgb_s2 <= rgb_s1;
	end

	// Stage 3: per-bin lanes of count and color sums; shifted down during the search.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int b = 0; b < MAX_LEVELS; b++) begin
				cnt_q[b] <= '0;
				sr_q[b]  <= '0;
				sg_q[b]  <= '0;
				sb_q[b]  <= '0;
			end
		end else if (v_s2) begin
			for (int b = 0; b < MAX_LEVELS; b++) begin
				if (bin_s2 == BW'(b)) begin
					cnt_q[b] <= cnt_q[b] + CNT_W'(1);
					sr_q[b]  <= sr_q[b] + SUM_W'(rgb_s2[2*CH_W +: CH_W]);
					sg_q[b]  <= sg_q[b] + SUM_W'(rgb_s2[CH_W +: CH_W]);
					sb_q[b]  <= sb_q[b] + SUM_W'(rgb_s2[0 +: CH_W]);
				end
			end
		end else if (state_q == B_SEARCH) begin
			for (int b = 0; b < MAX_LEVELS - 1; b++) begin
				cnt_q[b] <= cnt_q[b+1];
				sr_q[b]  <= sr_q[b+1];
				sg_q[b]  <= sg_q[b+1];
				sb_q[b]  <= sb_q[b+1];
			end
			cnt_q[MAX_LEVELS-1] <= '0;
			sr_q[MAX_LEVELS-1]  <= '0;
			sg_q[MAX_LEVELS-1]  <= '0;
			sb_q[MAX_LEVELS-1]  <= '0;
		end
	end

	// Division steps for the three color means.
	assign dr = div_step(rr_q, nr_q, best_q);
	assign dg = div_step(rg_q, ng_q, best_q);
	assign db = div_step(rb_q, nb_q, best_q);

	// Result fields.
	assign ix     = x_q - CW'(RADIUS);
	assign ix_ext = {{OUT_X_W{1'b0}}, ix};
	assign px_ext = {{OUT_X_W{1'b0}}, x_q};
	assign mean   = (best_q == '0) ? '0 : {nr_q[CH_W-1:0], ng_q[CH_W-1:0], nb_q[CH_W-1:0]};

	// Sequencer of the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
			kind_q      <= '0;
			feed_q      <= '0;
			srch_q      <= '0;
			iter_q      <= '0;
			best_q      <= '0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						kind_q <= cmd_kind;
						feed_q <= '0;
						if (cmd_kind.interior) begin
							state_q <= B_BIN;
						end else if (cmd_kind.pass) begin
							state_q <= B_EMIT_P;
						end
					end
				end
				B_BIN: begin
					if (feeding) begin
						feed_q <= feed_q + FW'(1);
					end else if (!v_s1 && !v_s2) begin
						srch_q  <= '0;
						best_q  <= '0;
						state_q <= B_SEARCH;
					end
				end
				B_SEARCH: begin
					if (cnt_q[0] > best_q) begin
						best_q <= cnt_q[0];
					end
					srch_q <= srch_q + LW'(1);
					if (srch_q == lv_eff - LW'(1)) begin
						iter_q  <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					iter_q <= iter_q + IW'(1);
					if (iter_q == IW'(SUM_W - 1)) begin
						state_q <= B_EMIT_I;
					end
				end
				B_EMIT_I: begin
					if (load_ok) begin
						state_q <= kind_q.pass ? B_EMIT_P : B_IDLE;
					end
				end
				B_EMIT_P: begin
					if (load_ok) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Payload registers: command fields, best bin, divider lanes and the output slot.
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q   <= cmd_x;
			y_q   <= cmd_y;
			pix_q <= cmd_col[(D-1)*PIX_W +: PIX_W];
		end
		if (state_q == B_SEARCH && cnt_q[0] > best_q) begin
			nr_q <= sr_q[0];
			ng_q <= sg_q[0];
			nb_q <= sb_q[0];
		end
		if (state_q == B_SEARCH) begin
			rr_q <= '0;
			rg_q <= '0;
			rb_q <= '0;
		end
		if (state_q == B_DIV) begin
			{rr_q, nr_q} <= dr;
			{rg_q, ng_q} <= dg;
			{rb_q, nb_q} <= db;
		end
		if (state_q == B_EMIT_I && load_ok) begin
			out_x_q   <= ix_ext[OUT_X_W-1:0];
			out_y_q   <= y_q - ROW_W'(RADIUS);
			out_pix_q <= mean;
			last_q    <= !kind_q.pass;
		end else if (state_q == B_EMIT_P && load_ok) begin
			out_x_q   <= px_ext[OUT_X_W-1:0];
			out_y_q   <= y_q;
			out_pix_q <= pix_q;
			last_q    <= 1'b1;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_red     = out_pix_q[2*CH_W +: CH_W];
	assign out_green   = out_pix_q[CH_W +: CH_W];
	assign out_blue    = out_pix_q[0 +: CH_W];
	assign last_of_run = last_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV |-> best_q != '0) else $error("fullest bin is empty");
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_SEARCH |-> !v_s1 && !v_s2) else $error("bin pipeline not drained");
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT_I && load_ok) |=> ((state_q == B_EMIT_P) == kind_q.pass))
		else $error("pass-through result not scheduled after interior result");

endmodule

/* hdl/oil_paint_filter.sv */
// Top level of the oil paint filter: configuration registers, front end, command queue, back end.
// Depends on ops_pkg, ops_front, ops_cmd_fifo and ops_back.
//
// Channel   Direction  Handshake              Payload
// pixel     in         pix_valid / pix_stall  frame_start, red, green, blue
// result    out        res_valid / res_stall  out_x, out_y, out_red, out_green, out_blue, last_of_run
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front end takes a new pixel only once the last one has gone into the queue (line store
// read, then write and queue push). The back end takes a new command only when idle; a
// border-only pixel just emits its pass-through result, an interior pixel goes through the
// window histogram, bin search and mean divider, so the histogram unit sets the throughput.
// Reset clears the position counters, the queue and the output slot and loads the register
// defaults; the line store is not cleared. Each side may stall independently through the
// two-entry queue and the output register.
module oil_paint_filter #(
	parameter int RADIUS     = 3,
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_LEVELS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic                              frame_start,
	input  logic [ops_pkg::CH_W-1:0]          red,
	input  logic [ops_pkg::CH_W-1:0]          green,
	input  logic [ops_pkg::CH_W-1:0]          blue,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [ops_pkg::OUT_X_W-1:0]       out_x,
	output logic [ops_pkg::ROW_W-1:0]         out_y,
	output logic [ops_pkg::CH_W-1:0]          out_red,
	output logic [ops_pkg::CH_W-1:0]          out_green,
	output logic [ops_pkg::CH_W-1:0]          out_blue,
	output logic                              last_of_run,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ops_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ops_pkg::CFG_W-1:0]         cfg_data
);
	import ops_pkg::*;

	localparam int D     = 2 * RADIUS + 1;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int COL_W = D * PIX_W;
	localparam int CMD_W = COL_W + $bits(ops_kind_t) + CW + ROW_W;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [LVL_W-1:0]  levels_q;

	logic              f_valid;
	logic              f_ready;
	logic [COL_W-1:0]  f_col;
	ops_kind_t         f_kind;
	logic [CW-1:0]     f_x;
	logic [ROW_W-1:0]  f_y;
	logic              b_valid;
	logic              b_ready;
	logic [CMD_W-1:0]  b_data;
	logic [COL_W-1:0]  b_col;
	ops_kind_t         b_kind;
	logic [CW-1:0]     b_x;
	logic [ROW_W-1:0]  b_y;

	// Configuration registers, always ready.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			levels_q <= LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				REG_LEVEL_COUNT:  levels_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	ops_front #(
		.RADIUS    (RADIUS),
		.MAX_WIDTH (MAX_WIDTH),
		.CW        (CW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.frame_start (frame_start),
		.pix         ({red, green, blue}),
		.cfg_width   (width_q),
		.cfg_height  (height_q),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd_col     (f_col),
		.cmd_kind    (f_kind),
		.cmd_x       (f_x),
		.cmd_y       (f_y)
	);

	ops_cmd_fifo #(
		.DATA_W (CMD_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_col, f_kind, f_x, f_y}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	assign {b_col, b_kind, b_x, b_y} = b_data;

	ops_back #(
		.RADIUS     (RADIUS),
		.MAX_LEVELS (MAX_LEVELS),
		.CW         (CW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (b_valid),
		.cmd_ready   (b_ready),
		.cmd_col     (b_col),
		.cmd_kind    (b_kind),
		.cmd_x       (b_x),
		.cmd_y       (b_y),
		.cfg_levels  (levels_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.last_of_run (last_of_run)
	);

endmodule

/* tb/oil_paint_checker.sv */
// Checker for the oil paint filter: watches the pixel, result and register channels,
// predicts each result from its own copy of the line store, window and registers, and compares.
// Depends on ops_pkg for widths and register indexes.
module oil_paint_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	input  logic                          pix_stall,
	input  logic                          frame_start,
	input  logic [ops_pkg::CH_W-1:0]      red,
	input  logic [ops_pkg::CH_W-1:0]      green,
	input  logic [ops_pkg::CH_W-1:0]      blue,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  logic [ops_pkg::OUT_X_W-1:0]   out_x,
	input  logic [ops_pkg::ROW_W-1:0]     out_y,
	input  logic [ops_pkg::CH_W-1:0]      out_red,
	input  logic [ops_pkg::CH_W-1:0]      out_green,
	input  logic [ops_pkg::CH_W-1:0]      out_blue,
	input  logic                          last_of_run,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ops_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ops_pkg::CFG_W-1:0]     cfg_data,
	output int                            errors,
	output int                            pending,
	output int                            n_results
);
	timeunit 1ns;
	timeprecision 1ps;
	import ops_pkg::*;

	localparam int RAD     = 3;
	localparam int DIAM    = 2 * RAD + 1;
	localparam int MAXW    = 2048;
	localparam int MAXLV   = 32;

	typedef struct {
		logic [OUT_X_W-1:0] x;
		logic [ROW_W-1:0]   y;
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    g;
		logic [CH_W-1:0]    b;
		logic               last;
	} paint_t;

	pixel_t          line_mem[MAXW * 2 * RAD];
	pixel_t          win[DIAM * DIAM];
	int unsigned     col_cnt;
	int unsigned     row_cnt;
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [LVL_W-1:0] level_reg;
	paint_t          paint_q[$];

	// Mean color of the most populated intensity bin of the current window.
	function automatic pixel_t window_color(input int unsigned lv);
		int unsigned cnt[MAXLV];
		int unsigned sr[MAXLV];
		int unsigned sg[MAXLV];
		int unsigned sb[MAXLV];
		int unsigned r, g, b, bin, best, bestc;
		for (int i = 0; i < MAXLV; i++) begin
			cnt[i] = 0; sr[i] = 0; sg[i] = 0; sb[i] = 0;
		end
		best = 0;
		bestc = 0;
		for (int i = 0; i < DIAM * DIAM; i++) begin
			r = win[i][23:16];
			g = win[i][15:8];
			b = win[i][7:0];
			bin = ((r + g + b) / 3) * lv / 256;
			if (bin >= lv)
				bin = lv - 1;
			cnt[bin]++;
			sr[bin] += r;
			sg[bin] += g;
			sb[bin] += b;
		end
		// Strictly greater keeps the lowest bin on a tie.
		for (int i = 0; i < lv; i++) begin
			if (cnt[i] > bestc) begin
				bestc = cnt[i];
				best = i;
			end
		end
		if (bestc == 0)
			return '0;
		return {8'(sr[best] / bestc), 8'(sg[best] / bestc), 8'(sb[best] / bestc)};
	endfunction

	// Advance the position, shift the window and queue the results of one pixel.
	function automatic void predict_pixel(input logic fs, input pixel_t pix);
		int unsigned w, h, lv, x, y, base;
		pixel_t column[DIAM];
		paint_t inner, edge_px;
		logic has_inner, has_edge;
		w = (width_reg == 0) ? 1 : ((width_reg > MAXW) ? MAXW : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		lv = (level_reg == 0) ? 1 : ((level_reg > MAXLV) ? MAXLV : level_reg);
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		// A shrunk width or height leaves the counters out of range: wrap them first.
		if (col_cnt >= w) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= h)
			row_cnt = 0;
		x = col_cnt;
		y = row_cnt;

		base = x * 2 * RAD;
		for (int k = 0; k < 2 * RAD; k++)
			column[k] = line_mem[base + k];
		column[2 * RAD] = pix;
		for (int k = 0; k < 2 * RAD; k++)
			line_mem[base + k] = column[k + 1];
		for (int c = 0; c < DIAM - 1; c++)
			for (int k = 0; k < DIAM; k++)
				win[c * DIAM + k] = win[(c + 1) * DIAM + k];
		for (int k = 0; k < DIAM; k++)
			win[(DIAM - 1) * DIAM + k] = column[k];

		has_inner = (x >= 2 * RAD) && (y >= 2 * RAD);
		has_edge = (x < RAD) || (y < RAD) || (x + RAD >= w) || (y + RAD >= h);
		// The finished window comes before the border pass-through, keeping raster order.
		if (has_inner) begin
			inner.x = OUT_X_W'(x - RAD);
			inner.y = ROW_W'(y - RAD);
			{inner.r, inner.g, inner.b} = window_color(lv);
			inner.last = !has_edge;
			paint_q.push_back(inner);
		end
		if (has_edge) begin
			edge_px.x = OUT_X_W'(x);
			edge_px.y = ROW_W'(y);
			{edge_px.r, edge_px.g, edge_px.b} = pix;
			edge_px.last = 1'b1;
			paint_q.push_back(edge_px);
		end

		if (x + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			col_cnt = x + 1;
		end
	endfunction

	// One line per wrong field; printing stops after a few dozen but counting goes on.
	task automatic report_mismatch(input string field, input int got, input int want,
			input int px, input int py);
		if (errors < 40)
			$display("[%0t] mismatch in %s at (%0d,%0d): got %0d, expected %0d",
				$realtime, field, px, py, got, want);
		errors++;
	endtask

	// Compare one accepted result transaction with the oldest expectation.
	task automatic check_result();
		paint_t want;
		if (paint_q.size() == 0) begin
			report_mismatch("unexpected result", 1, 0, out_x, out_y);
		end else begin
			want = paint_q.pop_front();
			if (out_x !== want.x)
				report_mismatch("out_x", out_x, want.x, want.x, want.y);
			if (out_y !== want.y)
				report_mismatch("out_y", out_y, want.y, want.x, want.y);
			if (out_red !== want.r)
				report_mismatch("out_red", out_red, want.r, want.x, want.y);
			if (out_green !== want.g)
				report_mismatch("out_green", out_green, want.g, want.x, want.y);
			if (out_blue !== want.b)
				report_mismatch("out_blue", out_blue, want.b, want.x, want.y);
			if (last_of_run !== want.last)
				report_mismatch("last_of_run", last_of_run, want.last, want.x, want.y);
		end
		n_results++;
	endtask

	// Follow every channel at the clock edge where its transactions take place.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			level_reg = LEVEL_RESET;
			col_cnt = 0;
			row_cnt = 0;
			paint_q.delete();
			errors = 0;
			n_results = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = cfg_data;
					REG_IMAGE_HEIGHT: height_reg = cfg_data;
					REG_LEVEL_COUNT: level_reg = cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				predict_pixel(frame_start, {red, green, blue});
			if (res_valid && !res_stall)
				check_result();
			pending = paint_q.size();
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top of the oil paint filter: clock, reset, pixel frames, register writes, verdict.
// Depends on ops_pkg, oil_paint_filter and oil_paint_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ops_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int SETTLE      = 300;
	localparam int N_ITEMS     = 1400;

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_stall;
	logic                 frame_start;
	logic [CH_W-1:0]      red;
	logic [CH_W-1:0]      green;
	logic [CH_W-1:0]      blue;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [OUT_X_W-1:0]   out_x;
	logic [ROW_W-1:0]     out_y;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic                 last_of_run;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   n_results;

	int     snd_idle;
	int     rcv_idle;
	int     n_pix;
	int     n_frames;
	int     quiet = 0;
	pixel_t palette[4];

	oil_paint_filter DUT (.*);

	oil_paint_checker u_check (.*);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// The result side stalls at random.
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < rcv_idle);

	// Watchdog: too long without any transaction ends the run.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// Drive one pixel transaction and hold it until it is taken.
	task automatic send_pixel(input logic fs, input pixel_t p);
		logic stalled;
		while ($urandom_range(99) < snd_idle) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		frame_start <= fs;
		{red, green, blue} <= p;
		do begin
			@(negedge clk);
			stalled = pix_stall;
			@(posedge clk);
		end while (stalled);
		n_pix++;
	endtask

	// Write one register and drop the request once it is taken.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(value);
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every expected result has come, then let a pixel with no result drain.
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Pixel content: random, a small palette for ties, saturated channels, or near-gray.
	function automatic pixel_t make_pixel(input int style);
		int v;
		case (style)
			0: return pixel_t'($urandom);
			1: return palette[$urandom_range(3)];
			2: return {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
				{8{1'($urandom_range(1))}}};
			default: begin
				v = $urandom_range(255);
				return {8'(v), 8'(v ^ $urandom_range(1)), 8'(v)};
			end
		endcase
	endfunction

	// Configure, then send one frame: cut to 40 pixels above 200, else now and then cut short; now and then restarted.
	task automatic run_frame(input int w, input int h, input int lv, input int style);
		int ew, eh, stop;
		settle();
		set_reg(REG_IMAGE_WIDTH, w);
		set_reg(REG_IMAGE_HEIGHT, h);
		set_reg(REG_LEVEL_COUNT, lv);
		ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
		eh = (h == 0) ? 1 : h;
		stop = ew * eh;
		if (stop > 200)
			stop = 40;
		else if ($urandom_range(9) == 0)
			stop = $urandom_range(1, stop);
		for (int i = 0; i < 4; i++)
			palette[i] = pixel_t'($urandom);
		for (int n = 0; n < stop; n++)
			send_pixel((n == 0) || ($urandom_range(299) == 0), make_pixel(style));
		n_frames++;
	endtask

	initial begin
		int w, h, lv, cur_w, cur_h;
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		frame_start <= 1'b0;
		red <= '0;
		green <= '0;
		blue <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		snd_idle = 7;
		rcv_idle = 57;
		n_pix = 0;
		n_frames = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero registers act as one pixel, one line and one bin: every pixel passes through.
		set_reg(REG_IMAGE_WIDTH, 0);
		set_reg(REG_IMAGE_HEIGHT, 0);
		set_reg(REG_LEVEL_COUNT, 0);
		send_pixel(1'b1, 24'h000000);
		send_pixel(1'b0, 24'hFFFFFF);
		send_pixel(1'b1, 24'hFF0000);
		send_pixel(1'b0, 24'h00FF00);
		send_pixel(1'b0, 24'h0000FF);
		send_pixel(1'b1, 24'hAA55AA);
		send_pixel(1'b0, 24'h55AA55);
		// The smallest frame with an interior pixel, at both level extremes and above the top.
		run_frame(7, 7, 32, 2);
		run_frame(7, 7, 1, 0);
		run_frame(8, 7, 63, 1);
		// A width above the largest line, the largest line itself and the tallest frame: a short stretch of border pixels.
		run_frame(4095, 4095, 20, 0);
		run_frame(2048, 3, 32, 3);

		// Random frames, mostly small, over the three idling schemes.
		while (n_pix < N_ITEMS) begin
			if (n_pix < N_ITEMS / 3) begin
				snd_idle = 7;
				rcv_idle = 57;
			end else if (n_pix < 2 * N_ITEMS / 3) begin
				snd_idle = 57;
				rcv_idle = 7;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			w = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 14);
			h = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 11);
			case ($urandom_range(7))
				0: lv = 0;
				1: lv = 1;
				2: lv = 32;
				3: lv = 63;
				default: lv = $urandom_range(2, 31);
			endcase
			run_frame(w, h, lv, $urandom_range(3));
			// Now and then shrink the image mid-frame and carry on without a frame start.
			cur_w = (w == 0) ? 1 : w;
			cur_h = (h == 0) ? 1 : h;
			if ($urandom_range(7) == 0 && cur_w > 1) begin
				settle();
				set_reg(REG_IMAGE_WIDTH, $urandom_range(1, cur_w - 1));
				set_reg(REG_IMAGE_HEIGHT, $urandom_range(1, cur_h));
				for (int n = 0; n < 30; n++)
					send_pixel(1'b0, make_pixel(0));
			end
		end

		settle();
		$display("Checked %0d results from %0d pixels in %0d frames,", n_results, n_pix, n_frames);
		$display("covering border, interior, shrunk and clamped geometries; %0d mismatches.", errors);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ops_pkg.sv
hdl/ops_front.sv
hdl/ops_cmd_fifo.sv
hdl/ops_back.sv
hdl/oil_paint_filter.sv
tb/oil_paint_checker.sv
tb/tb.sv
